// ===== design/blm_pkg.sv =====
// Shared types, constants and defaults for the battery level alert monitor.
// Used by every module in the design folder; depends on nothing.
package blm_pkg;

  // Defaults for the top-level parameters
  localparam int ADC_BITS_DEF  = 12;
  localparam int TIME_BITS_DEF = 48;
  localparam int SKIP_DEF      = 1;
  localparam int RECORD_DEF    = 1;

  // Field and register widths
  localparam int PCT_W      = 7;
  localparam int MVCFG_W    = 16;
  localparam int KOHM_W     = 10;
  localparam int RPT_W      = 48;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths
  localparam int ADC_MV_W = 12;  // converter millivolts, at most 3300
  localparam int MV_W     = 23;  // battery millivolts, at most 3300 * 2046
  localparam int MUL_A_W  = 16;
  localparam int MUL_B_W  = 12;
  localparam int DVS_W    = 16;  // divisor width of the shared divider

  localparam logic [ADC_MV_W-1:0] ADC_REF_MV = 12'd3300;
  localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;

  // Register reset values
  localparam logic [PCT_W-1:0]   ALERT_PCT_RST   = 7'd20;
  localparam logic [PCT_W-1:0]   PROTECT_PCT_RST = 7'd10;
  localparam logic [PCT_W-1:0]   HYST_PCT_RST    = 7'd5;
  localparam logic [MVCFG_W-1:0] EMPTY_MV_RST    = 16'd3300;
  localparam logic [MVCFG_W-1:0] FULL_MV_RST     = 16'd4200;
  localparam logic [KOHM_W-1:0]  DIV_TOP_RST     = 10'd100;
  localparam logic [KOHM_W-1:0]  DIV_BOT_RST     = 10'd100;
  localparam logic [RPT_W-1:0]   REPEAT_US_RST   = 48'd60000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALERT_PCT   = 3'd0,
    CFG_PROTECT_PCT = 3'd1,
    CFG_HYST_PCT    = 3'd2,
    CFG_EMPTY_MV    = 3'd3,
    CFG_FULL_MV     = 3'd4,
    CFG_DIV_TOP     = 3'd5,
    CFG_DIV_BOT     = 3'd6,
    CFG_REPEAT_US   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_FOLD,
    ST_MUL2,
    ST_GO2,
    ST_DIV2,
    ST_SCALE,
    ST_GO3,
    ST_DIV3,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic [PCT_W-1:0] warn_lvl;
    logic [PCT_W-1:0] guard_lvl;
    logic [PCT_W-1:0] hyst_pct;
  } thr_cfg_t;

  typedef struct packed {
    logic play;
    logic stop;
    logic low_chg;
    logic allowed;
  } alert_res_t;

endpackage

// ===== design/blm_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on blm_pkg for the divisor width.
module blm_divider #(
  parameter int DIV_W = 28,
  localparam int CNT_W = $clog2(DIV_W + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIV_W-1:0]          dividend_i,
  input  logic [blm_pkg::DVS_W-1:0] divisor_i,
  input  logic [CNT_W-1:0]          nbits_i,
  output logic                      done_o,
  output logic [DIV_W-1:0]          quotient_o
);

  localparam int DW = blm_pkg::DVS_W;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DW:0]      partial;
  logic [DW+1:0]    trial;
  logic             borrow;

  // Caller guarantees dividend < divisor * 2^nbits, so the remainder
  // seeded from the upper dividend bits already fits.
  always_comb begin
    partial = {rem_q, quo_q[DIV_W-1]};
    trial   = {1'b0, partial} - {2'b00, dvs_q};
    borrow  = trial[DW+1];
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d = nbits_i;
      dvs_d = divisor_i;
      rem_d = DW'(dividend_i >> nbits_i);
      quo_d = dividend_i << (DIV_W - int'(nbits_i));
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = borrow ? partial[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[DIV_W-2:0], ~borrow};
    end
    done_d = !start_i && (cnt_q == CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/blm_alert.sv =====
// Threshold tracking, alert decision and alert history registers.
// Depends on blm_pkg for the threshold and result structs.
module blm_alert #(
  parameter int TIME_BITS = blm_pkg::TIME_BITS_DEF,
  parameter int SKIP      = blm_pkg::SKIP_DEF,
  parameter int RECORD    = blm_pkg::RECORD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          commit_i,
  input  logic [blm_pkg::PCT_W-1:0]     pct_i,
  input  logic                          charging_i,
  input  logic [TIME_BITS-1:0]          now_i,
  input  blm_pkg::thr_cfg_t             thr_i,
  input  logic [blm_pkg::RPT_W-1:0]     repeat_i,
  output blm_pkg::alert_res_t           res_o,
  output logic [blm_pkg::PCT_W-1:0]     last_pct_o
);

  localparam int PW    = blm_pkg::PCT_W;
  localparam int CMP_W = 64;

  logic [PW-1:0]        last_pct_q;
  logic                 alert_armed_q, protect_armed_q, alerted_q;
  logic [TIME_BITS-1:0] last_time_q;

  logic [PW:0]          alert_rearm, protect_rearm;
  logic                 under_warn, under_guard;
  logic                 alert_armed, protect_armed;
  logic                 warn_new, guard_new, interval_due, fire, suppress;
  logic [TIME_BITS-1:0] elapsed;

  always_comb begin
    alert_rearm   = {1'b0, thr_i.warn_lvl} + {1'b0, thr_i.hyst_pct};
    protect_rearm = {1'b0, thr_i.guard_lvl} + {1'b0, thr_i.hyst_pct};
    under_warn    = pct_i <= thr_i.warn_lvl;
    under_guard   = pct_i <= thr_i.guard_lvl;
    alert_armed   = alert_armed_q | ({1'b0, pct_i} > alert_rearm);
    protect_armed = protect_armed_q | ({1'b0, pct_i} > protect_rearm);
    elapsed       = now_i - last_time_q;
    interval_due  = !alerted_q || (CMP_W'(elapsed) >= CMP_W'(repeat_i));
    warn_new      = alert_armed;
    guard_new     = under_guard && protect_armed;
    fire          = under_warn && (warn_new || guard_new || interval_due);
    suppress      = (SKIP != 0) && charging_i;
    res_o.play    = fire;
    res_o.stop    = fire && guard_new && !suppress;
    res_o.low_chg = fire && guard_new && charging_i && suppress;
    res_o.allowed = ((RECORD != 0) && charging_i) || !under_guard;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pct_q      <= blm_pkg::PCT_FULL;
      alert_armed_q   <= 1'b1;
      protect_armed_q <= 1'b1;
      alerted_q       <= 1'b0;
      last_time_q     <= '0;
    end else if (commit_i) begin
      last_pct_q      <= pct_i;
      alert_armed_q   <= alert_armed && !fire;
      protect_armed_q <= protect_armed && !(fire && under_guard);
      if (fire) begin
        alerted_q   <= 1'b1;
        last_time_q <= now_i;
      end
    end
  end

  assign last_pct_o = last_pct_q;

endmodule

// ===== design/battery_level_alert_monitor.sv =====
// Battery level alert monitor: top level with sequencer, registers and output stage.
// A good read steps through MUL1, FOLD, MUL2, GO2, DIV2, SCALE, GO3, DIV3 and DECIDE; when the
// percent clamps to 0 or 100 it skips GO3 and DIV3, and a failed read goes straight to DECIDE.
// The shared divider gives the 23 + 7 quotient bits, one per cycle, and FOLD repeats by the top
// code; one sample is in flight at a time. A result held at the output stalls the next sample.
// Reset: async active low, registers to defaults; uses blm_pkg, blm_divider, blm_alert.
module battery_level_alert_monitor #(
  parameter int ADC_BITS  = blm_pkg::ADC_BITS_DEF,
  parameter int TIME_BITS = blm_pkg::TIME_BITS_DEF,
  parameter int SKIP      = blm_pkg::SKIP_DEF,
  parameter int RECORD    = blm_pkg::RECORD_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [blm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [blm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ADC_BITS-1:0]                adc_raw_i,
  input  logic                               adc_ok_i,
  input  logic                               charger_active_i,
  input  logic [TIME_BITS-1:0]               sample_time_us_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [blm_pkg::PCT_W-1:0]          battery_percent_o,
  output logic                               play_alert_o,
  output logic                               stop_recording_o,
  output logic                               low_but_charging_o,
  output logic                               record_allowed_o
);

  localparam int PW     = blm_pkg::PCT_W;
  localparam int MW     = blm_pkg::MV_W;
  localparam int AMW    = blm_pkg::ADC_MV_W;
  localparam int DW     = blm_pkg::DVS_W;
  localparam int MAW    = blm_pkg::MUL_A_W;
  localparam int MBW    = blm_pkg::MUL_B_W;
  localparam int DIV_W  = (ADC_BITS + AMW > MW) ? (ADC_BITS + AMW) : MW;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] ADC_MAX = DIV_W'((64'd1 << ADC_BITS) - 64'd1);

  // ---------------------------------------------------------------------------
  // Configuration registers: the user writes them only while the block is idle, not enforced
  // ---------------------------------------------------------------------------
  blm_pkg::thr_cfg_t              thr_q;
  logic [blm_pkg::MVCFG_W-1:0]    empty_mv_q, full_mv_q;
  logic [blm_pkg::KOHM_W-1:0]     div_top_q, div_bot_q;
  logic [blm_pkg::RPT_W-1:0]      repeat_us_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.warn_lvl    <= blm_pkg::ALERT_PCT_RST;
      thr_q.guard_lvl   <= blm_pkg::PROTECT_PCT_RST;
      thr_q.hyst_pct    <= blm_pkg::HYST_PCT_RST;
      empty_mv_q        <= blm_pkg::EMPTY_MV_RST;
      full_mv_q         <= blm_pkg::FULL_MV_RST;
      div_top_q         <= blm_pkg::DIV_TOP_RST;
      div_bot_q         <= blm_pkg::DIV_BOT_RST;
      repeat_us_q       <= blm_pkg::REPEAT_US_RST;
    end else if (cfg_we_i) begin
      case (blm_pkg::cfg_idx_e'(cfg_idx_i))
        blm_pkg::CFG_ALERT_PCT:   thr_q.warn_lvl    <= cfg_wdata_i[PW-1:0];
        blm_pkg::CFG_PROTECT_PCT: thr_q.guard_lvl   <= cfg_wdata_i[PW-1:0];
        blm_pkg::CFG_HYST_PCT:    thr_q.hyst_pct    <= cfg_wdata_i[PW-1:0];
        blm_pkg::CFG_EMPTY_MV:    empty_mv_q  <= cfg_wdata_i[blm_pkg::MVCFG_W-1:0];
        blm_pkg::CFG_FULL_MV:     full_mv_q   <= cfg_wdata_i[blm_pkg::MVCFG_W-1:0];
        blm_pkg::CFG_DIV_TOP:     div_top_q   <= cfg_wdata_i[blm_pkg::KOHM_W-1:0];
        blm_pkg::CFG_DIV_BOT:     div_bot_q   <= cfg_wdata_i[blm_pkg::KOHM_W-1:0];
        blm_pkg::CFG_REPEAT_US:   repeat_us_q <= cfg_wdata_i[blm_pkg::RPT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and sample registers
  // ---------------------------------------------------------------------------
  blm_pkg::state_e      state_q, state_d;
  logic [ADC_BITS-1:0]  raw_q;
  logic                 chg_q;
  logic [TIME_BITS-1:0] time_q;
  logic [DIV_W-1:0]     prod_q;
  logic [AMW-1:0]       adc_mv_q;
  logic [MW-1:0]        mv_q;
  logic [PW-1:0]        pct_q;

  logic                 out_valid_q;
  logic [PW-1:0]        out_pct_q;
  blm_pkg::alert_res_t  out_res_q;

  // control from the output decoder
  logic                 in_fire, good_read, commit, div_start;
  logic [MAW-1:0]       mul_a;
  logic [MBW-1:0]       mul_b;
  logic [MAW+MBW-1:0]   mul_res;
  logic [DW-1:0]        div_divisor;
  logic [CNT_W-1:0]     div_nbits;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;

  // division by the all-ones top code: fold the bits above the code width back in
  logic [DIV_W-1:0]     fold_hi, fold_lo;

  // scaling compares on battery millivolts
  logic [DW-1:0]        span;
  logic [MW-1:0]        mv_above;
  logic                 at_empty, no_span, at_full;
  logic [blm_pkg::KOHM_W:0] div_sum;

  blm_pkg::alert_res_t  alert_res;
  logic [PW-1:0]        last_pct;

  always_comb begin
    span     = full_mv_q - empty_mv_q;
    mv_above = mv_q - MW'(empty_mv_q);
    at_empty = mv_q <= MW'(empty_mv_q);
    no_span  = full_mv_q <= empty_mv_q;
    at_full  = mv_above >= MW'(span);
    div_sum  = {1'b0, div_top_q} + {1'b0, div_bot_q};
    mul_res  = mul_a * mul_b;
    fold_hi  = prod_q >> ADC_BITS;
    fold_lo  = prod_q & ADC_MAX;
  end

  assign in_fire   = in_valid_i && in_ready_o;
  assign good_read = adc_ok_i && (div_bot_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      blm_pkg::ST_IDLE:
        if (in_fire) begin
          state_d = good_read ? blm_pkg::ST_MUL1 : blm_pkg::ST_DECIDE;
        end
      blm_pkg::ST_MUL1: state_d = blm_pkg::ST_FOLD;
      blm_pkg::ST_FOLD: if (fold_hi == '0) state_d = blm_pkg::ST_MUL2;
      blm_pkg::ST_MUL2: state_d = blm_pkg::ST_GO2;
      blm_pkg::ST_GO2:  state_d = blm_pkg::ST_DIV2;
      blm_pkg::ST_DIV2: if (div_done) state_d = blm_pkg::ST_SCALE;
      blm_pkg::ST_SCALE: begin
        if (at_empty || no_span || at_full) begin
          state_d = blm_pkg::ST_DECIDE;
        end else begin
          state_d = blm_pkg::ST_GO3;
        end
      end
      blm_pkg::ST_GO3:  state_d = blm_pkg::ST_DIV3;
      blm_pkg::ST_DIV3: if (div_done) state_d = blm_pkg::ST_DECIDE;
      blm_pkg::ST_DECIDE: if (commit) state_d = blm_pkg::ST_IDLE;
      default: state_d = blm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: operand steering for the multiplier and divider
  always_comb begin
    in_ready_o  = 1'b0;
    commit      = 1'b0;
    div_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_divisor = '0;
    div_nbits   = '0;
    case (state_q)
      blm_pkg::ST_IDLE: in_ready_o = 1'b1;
      // converter millivolts: raw * 3300 / top code, the division folded in ST_FOLD
      blm_pkg::ST_MUL1: begin
        mul_a = MAW'(raw_q);
        mul_b = MBW'(blm_pkg::ADC_REF_MV);
      end
      // battery millivolts: adc_mv * (top + bottom) / bottom
      blm_pkg::ST_MUL2: begin
        mul_a = MAW'(adc_mv_q);
        mul_b = MBW'(div_sum);
      end
      blm_pkg::ST_GO2: begin
        div_start   = 1'b1;
        div_divisor = DW'(div_bot_q);
        div_nbits   = CNT_W'(MW);
      end
      // percent: (mv - empty) * 100 / (full - empty), quotient below 100 here
      blm_pkg::ST_SCALE: begin
        mul_a = mv_above[MAW-1:0];
        mul_b = MBW'(blm_pkg::PCT_FULL);
      end
      blm_pkg::ST_GO3: begin
        div_start   = 1'b1;
        div_divisor = span;
        div_nbits   = CNT_W'(PW);
      end
      blm_pkg::ST_DECIDE: commit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result wins over the hand-off of the old one
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; hold unless the sequencer moves them
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q  <= adc_raw_i;
      chg_q  <= charger_active_i;
      time_q <= sample_time_us_i;
      pct_q  <= last_pct;   // kept as is on a failed read
    end
    if (state_q == blm_pkg::ST_MUL1 || state_q == blm_pkg::ST_MUL2 ||
        state_q == blm_pkg::ST_SCALE) begin
      prod_q <= DIV_W'(mul_res);
    end
    if (state_q == blm_pkg::ST_MUL1) begin
      adc_mv_q <= '0;
    end
    // x = q * top + r: move the upper bits into the quotient until r fits the
    // code width, then take one more when r equals the top code itself
    if (state_q == blm_pkg::ST_FOLD) begin
      if (fold_hi != '0) begin
        prod_q   <= fold_lo + fold_hi;
        adc_mv_q <= adc_mv_q + fold_hi[AMW-1:0];
      end else if (prod_q == ADC_MAX) begin
        adc_mv_q <= adc_mv_q + AMW'(1);
      end
    end
    if (state_q == blm_pkg::ST_DIV2 && div_done) begin
      mv_q <= div_quo[MW-1:0];
    end
    if (state_q == blm_pkg::ST_SCALE) begin
      if (at_empty) begin
        pct_q <= '0;
      end else if (no_span || at_full) begin
        pct_q <= blm_pkg::PCT_FULL;
      end
    end
    if (state_q == blm_pkg::ST_DIV3 && div_done) begin
      pct_q <= div_quo[PW-1:0];
    end
    if (commit) begin
      out_pct_q <= pct_q;
      out_res_q <= alert_res;
    end
  end

  blm_divider #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (div_divisor),
    .nbits_i    (div_nbits),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  blm_alert #(
    .TIME_BITS (TIME_BITS),
    .SKIP      (SKIP),
    .RECORD    (RECORD)
  ) u_alert (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (commit),
    .pct_i      (pct_q),
    .charging_i (chg_q),
    .now_i      (time_q),
    .thr_i      (thr_q),
    .repeat_i   (repeat_us_q),
    .res_o      (alert_res),
    .last_pct_o (last_pct)
  );

  assign out_valid_o        = out_valid_q;
  assign battery_percent_o  = out_pct_q;
  assign play_alert_o       = out_res_q.play;
  assign stop_recording_o   = out_res_q.stop;
  assign low_but_charging_o = out_res_q.low_chg;
  assign record_allowed_o   = out_res_q.allowed;

endmodule

// ===== design/blm_checker.sv =====
// Port-level checks for the battery level alert monitor, with its bind.
// Depends on blm_pkg and on battery_level_alert_monitor.
module blm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [blm_pkg::PCT_W-1:0]      battery_percent_o,
  input logic                           play_alert_o,
  input logic                           stop_recording_o,
  input logic                           low_but_charging_o,
  input logic                           record_allowed_o
);

  // stop and suppressed-stop only accompany an alert
  a_stop_needs_alert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stop_recording_o || low_but_charging_o) |-> play_alert_o)
    else $error("stop or low_but_charging without play_alert");

  a_stop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(stop_recording_o && low_but_charging_o))
    else $error("stop_recording and low_but_charging both set");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> battery_percent_o <= blm_pkg::PCT_FULL)
    else $error("battery_percent above full");

  // one sample at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accepting a sample");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(battery_percent_o) &&
      $stable(play_alert_o) && $stable(record_allowed_o))
    else $error("stalled result changed");

endmodule

bind battery_level_alert_monitor blm_checker u_blm_checker (.*);

// ===== test/battery_level_alert_checker.sv =====
// Checker for the battery level alert monitor: follows the register port and both channels,
// predicts each result from the accepted sample and compares it field by field.
// Depends on blm_pkg only.
module battery_level_alert_checker #(
  parameter int ADC_BITS  = blm_pkg::ADC_BITS_DEF,
  parameter int TIME_BITS = blm_pkg::TIME_BITS_DEF,
  parameter int SKIP      = blm_pkg::SKIP_DEF,
  parameter int RECORD    = blm_pkg::RECORD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [blm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [ADC_BITS-1:0]            adc_raw_i,
  input  logic                           adc_ok_i,
  input  logic                           charger_active_i,
  input  logic [TIME_BITS-1:0]           sample_time_us_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [blm_pkg::PCT_W-1:0]      battery_percent_i,
  input  logic                           play_alert_i,
  input  logic                           stop_recording_i,
  input  logic                           low_but_charging_i,
  input  logic                           record_allowed_i,
  output int                             fail_count_o,
  output int                             outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import blm_pkg::*;

  localparam logic [63:0] ADC_FULL_CODE = (64'd1 << ADC_BITS) - 64'd1;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    alert_res_t       flags;
  } battery_status_t;

  // register copy
  logic [PCT_W-1:0]   cfg_alert, cfg_protect, cfg_hyst;
  logic [MVCFG_W-1:0] cfg_empty, cfg_full;
  logic [KOHM_W-1:0]  cfg_rtop, cfg_rbot;
  logic [RPT_W-1:0]   cfg_repeat;

  // monitor state
  logic [PCT_W-1:0]     soc_pct;
  logic                 alert_arm, protect_arm, prompted_once;
  logic [TIME_BITS-1:0] last_prompt_us;

  battery_status_t battery_status_q[$];
  battery_status_t want, got;
  int              mismatches;

  assign fail_count_o = mismatches;

  function automatic battery_status_t battery_status_after(
    input logic [ADC_BITS-1:0]  raw,
    input logic                 ok,
    input logic                 chg,
    input logic [TIME_BITS-1:0] now_us
  );
    battery_status_t      st;
    logic [63:0]          conv_mv, batt_mv, pct;
    logic [TIME_BITS-1:0] elapsed;
    logic                 under_warn, under_guard, warn_new, guard_new;
    logic                 interval_due, hold_protect;
    pct = 64'(soc_pct);
    // a failed read or an open lower resistor keeps the previous percent
    if (ok && cfg_rbot != '0) begin
      conv_mv = 64'(raw) * 64'(ADC_REF_MV) / ADC_FULL_CODE;
      batt_mv = conv_mv * (64'(cfg_rtop) + 64'(cfg_rbot)) / 64'(cfg_rbot);
      if (batt_mv <= 64'(cfg_empty)) begin
        pct = 64'd0;
      end else if (cfg_full <= cfg_empty) begin
        pct = 64'(PCT_FULL);
      end else begin
        pct = (batt_mv - 64'(cfg_empty)) * 64'(PCT_FULL) / (64'(cfg_full) - 64'(cfg_empty));
        if (pct > 64'(PCT_FULL)) pct = 64'(PCT_FULL);
      end
    end
    soc_pct     = pct[PCT_W-1:0];
    under_warn  = soc_pct <= cfg_alert;
    under_guard = soc_pct <= cfg_protect;
    if (int'(soc_pct) > int'(cfg_alert) + int'(cfg_hyst)) alert_arm = 1'b1;
    if (int'(soc_pct) > int'(cfg_protect) + int'(cfg_hyst)) protect_arm = 1'b1;
    st.pct   = soc_pct;
    st.flags = '0;
    if (under_warn) begin
      warn_new      = alert_arm;
      guard_new     = under_guard && protect_arm;
      elapsed       = now_us - last_prompt_us;  // wraps with the timestamp
      interval_due  = !prompted_once || (64'(elapsed) >= 64'(cfg_repeat));
      if (warn_new || guard_new || interval_due) begin
        hold_protect      = (SKIP != 0) && chg;
        st.flags.play     = 1'b1;
        st.flags.stop     = guard_new && !hold_protect;
        st.flags.low_chg  = guard_new && chg && !st.flags.stop;
        last_prompt_us    = now_us;
        prompted_once     = 1'b1;
        alert_arm         = 1'b0;
        if (under_guard) protect_arm = 1'b0;
      end
    end
    st.flags.allowed = ((RECORD != 0) && chg) || (soc_pct > cfg_protect);
    return st;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_alert      = ALERT_PCT_RST;
      cfg_protect    = PROTECT_PCT_RST;
      cfg_hyst       = HYST_PCT_RST;
      cfg_empty      = EMPTY_MV_RST;
      cfg_full       = FULL_MV_RST;
      cfg_rtop       = DIV_TOP_RST;
      cfg_rbot       = DIV_BOT_RST;
      cfg_repeat     = REPEAT_US_RST;
      soc_pct        = PCT_FULL;
      alert_arm      = 1'b1;
      protect_arm    = 1'b1;
      prompted_once  = 1'b0;
      last_prompt_us = '0;
      mismatches     = 0;
      battery_status_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALERT_PCT:   cfg_alert   = cfg_wdata_i[PCT_W-1:0];
          CFG_PROTECT_PCT: cfg_protect = cfg_wdata_i[PCT_W-1:0];
          CFG_HYST_PCT:    cfg_hyst    = cfg_wdata_i[PCT_W-1:0];
          CFG_EMPTY_MV:    cfg_empty   = cfg_wdata_i[MVCFG_W-1:0];
          CFG_FULL_MV:     cfg_full    = cfg_wdata_i[MVCFG_W-1:0];
          CFG_DIV_TOP:     cfg_rtop    = cfg_wdata_i[KOHM_W-1:0];
          CFG_DIV_BOT:     cfg_rbot    = cfg_wdata_i[KOHM_W-1:0];
          CFG_REPEAT_US:   cfg_repeat  = cfg_wdata_i[RPT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.pct           = battery_percent_i;
        got.flags.play    = play_alert_i;
        got.flags.stop    = stop_recording_i;
        got.flags.low_chg = low_but_charging_i;
        got.flags.allowed = record_allowed_i;
        if (battery_status_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with no sample waiting, expected none, got percent %0d",
                   $time, got.pct);
        end else begin
          want = battery_status_q.pop_front();
          check_field("battery_percent", want.pct, got.pct);
          check_field("play_alert", want.flags.play, got.flags.play);
          check_field("stop_recording", want.flags.stop, got.flags.stop);
          check_field("low_but_charging", want.flags.low_chg, got.flags.low_chg);
          check_field("record_allowed", want.flags.allowed, got.flags.allowed);
        end
      end
      if (in_valid_i && in_ready_i) begin
        battery_status_q.push_back(battery_status_after(adc_raw_i, adc_ok_i,
                                                        charger_active_i, sample_time_us_i));
      end
      outstanding_o <= battery_status_q.size();
    end
  end

endmodule

// ===== test/tb_battery_level_alert_monitor.sv =====
// Testbench top for the battery level alert monitor: clock, reset, register writes,
// sample and result traffic with random idling, and the verdict.
// Depends on blm_pkg, the monitor RTL and battery_level_alert_checker.
module tb_battery_level_alert_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  import blm_pkg::*;

  localparam int ADC_BITS        = ADC_BITS_DEF;
  localparam int TIME_BITS       = TIME_BITS_DEF;
  localparam int SETTLE_CYCLES   = 60;   // enough for a good read to run through the sequencer
  localparam int HOLD_OFF_CYCLES = 800;  // long enough to back the block up
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_SAMPLES   = 160;
  localparam int PRESSURE_PHASE  = 5;

  typedef struct packed {
    logic [PCT_W-1:0]   alert;
    logic [PCT_W-1:0]   protect;
    logic [PCT_W-1:0]   hyst;
    logic [MVCFG_W-1:0] empty;
    logic [MVCFG_W-1:0] full;
    logic [KOHM_W-1:0]  rtop;
    logic [KOHM_W-1:0]  rbot;
    logic [RPT_W-1:0]   repeat_us;
  } monitor_setting_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ADC_BITS-1:0]   adc_raw_i;
  logic                  adc_ok_i;
  logic                  charger_active_i;
  logic [TIME_BITS-1:0]  sample_time_us_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PCT_W-1:0]      battery_percent_o;
  logic                  play_alert_o;
  logic                  stop_recording_o;
  logic                  low_but_charging_o;
  logic                  record_allowed_o;

  int fail_count;
  int outstanding;

  // hold_off_req is shared between the sample and result processes; the rest belong to one side
  bit hold_off_req = 1'b0;
  bit tx_burst     = 1'b0;
  int tx_streak    = 0;
  int rx_streak    = 0;

  // random walk state of the sample stream
  logic [TIME_BITS-1:0] clock_us = '0;
  logic                 charging = 1'b0;

  always #10 clk_i = ~clk_i;

  battery_level_alert_monitor u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .adc_raw_i          (adc_raw_i),
    .adc_ok_i           (adc_ok_i),
    .charger_active_i   (charger_active_i),
    .sample_time_us_i   (sample_time_us_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .battery_percent_o  (battery_percent_o),
    .play_alert_o       (play_alert_o),
    .stop_recording_o   (stop_recording_o),
    .low_but_charging_o (low_but_charging_o),
    .record_allowed_o   (record_allowed_o)
  );

  battery_level_alert_checker u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .adc_raw_i          (adc_raw_i),
    .adc_ok_i           (adc_ok_i),
    .charger_active_i   (charger_active_i),
    .sample_time_us_i   (sample_time_us_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .battery_percent_i  (battery_percent_o),
    .play_alert_i       (play_alert_o),
    .stop_recording_i   (stop_recording_o),
    .low_but_charging_i (low_but_charging_o),
    .record_allowed_i   (record_allowed_o),
    .fail_count_o       (fail_count),
    .outstanding_o      (outstanding)
  );

  // Idle length before the next transaction: mostly none or short, a few long,
  // and now and then a streak with no idling at all.
  function automatic int idle_len(inout int streak);
    int r;
    if (streak > 0) begin
      streak--;
      return 0;
    end
    r = int'($urandom_range(0, 99));
    if (r < 4) begin
      streak = int'($urandom_range(10, 40));
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 15));
    return int'($urandom_range(40, 160));
  endfunction

  function automatic monitor_setting_t default_setting();
    monitor_setting_t s;
    s.alert     = ALERT_PCT_RST;
    s.protect   = PROTECT_PCT_RST;
    s.hyst      = HYST_PCT_RST;
    s.empty     = EMPTY_MV_RST;
    s.full      = FULL_MV_RST;
    s.rtop      = DIV_TOP_RST;
    s.rbot      = DIV_BOT_RST;
    s.repeat_us = REPEAT_US_RST;
    return s;
  endfunction

  // Sensible settings most of the time; wild ones cover whole register widths,
  // including inverted thresholds and an open lower resistor.
  function automatic monitor_setting_t random_setting(input bit wild);
    monitor_setting_t s;
    logic [63:0]      r64;
    r64 = {$urandom, $urandom};
    if (wild) begin
      s.alert     = PCT_W'($urandom_range(0, 127));
      s.protect   = PCT_W'($urandom_range(0, 127));
      s.hyst      = PCT_W'($urandom_range(0, 127));
      s.empty     = MVCFG_W'($urandom_range(0, 65535));
      s.full      = MVCFG_W'($urandom_range(0, 65535));
      s.rtop      = KOHM_W'($urandom_range(0, 1023));
      s.rbot      = KOHM_W'($urandom_range(0, 1023));
      s.repeat_us = r64[RPT_W-1:0] >> $urandom_range(0, RPT_W - 1);
    end else begin
      s.alert     = PCT_W'($urandom_range(5, 60));
      s.protect   = PCT_W'($urandom_range(0, int'(s.alert) - 1));
      s.hyst      = PCT_W'($urandom_range(0, 15));
      s.empty     = MVCFG_W'($urandom_range(2800, 3600));
      s.full      = s.empty + MVCFG_W'($urandom_range(200, 1500));
      s.rtop      = KOHM_W'($urandom_range(50, 300));
      s.rbot      = KOHM_W'($urandom_range(50, 300));
      s.repeat_us = RPT_W'($urandom_range(0, 2000000));
    end
    return s;
  endfunction

  // Converter code that reads back as roughly the given battery voltage.
  function automatic int code_for_mv(input int mv, input monitor_setting_t s);
    longint den, code;
    den = (longint'(s.rtop) + longint'(s.rbot)) * longint'(ADC_REF_MV);
    if (s.rbot == '0 || den == 0) return 0;
    code = longint'(mv) * longint'(s.rbot) * ((longint'(1) << ADC_BITS) - 1) / den;
    if (code > (longint'(1) << ADC_BITS) - 1) return (1 << ADC_BITS) - 1;
    return int'(code);
  endfunction

  task automatic program_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Write every register; only called while nothing is in flight.
  task automatic apply_setting(input monitor_setting_t s);
    program_reg(CFG_ALERT_PCT, CFG_DATA_W'(s.alert));
    program_reg(CFG_PROTECT_PCT, CFG_DATA_W'(s.protect));
    program_reg(CFG_HYST_PCT, CFG_DATA_W'(s.hyst));
    program_reg(CFG_EMPTY_MV, CFG_DATA_W'(s.empty));
    program_reg(CFG_FULL_MV, CFG_DATA_W'(s.full));
    program_reg(CFG_DIV_TOP, CFG_DATA_W'(s.rtop));
    program_reg(CFG_DIV_BOT, CFG_DATA_W'(s.rbot));
    program_reg(CFG_REPEAT_US, CFG_DATA_W'(s.repeat_us));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one sample and hold it until the transaction completes. Valid is only
  // dropped when an idle gap follows, so back-to-back samples keep it high.
  task automatic send_sample(input logic [ADC_BITS-1:0] raw, input logic ok,
                             input logic chg, input logic [TIME_BITS-1:0] t_us);
    int gap;
    gap = tx_burst ? 0 : idle_len(tx_streak);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    adc_raw_i        <= raw;
    adc_ok_i         <= ok;
    charger_active_i <= chg;
    sample_time_us_i <= t_us;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait until every predicted result has been taken, then let the
  // pipeline run dry before anything is reprogrammed.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sweep the reading up and down across the percent window of this setting so
  // both thresholds are crossed repeatedly, with noise, failed reads, charger
  // toggles and time steps spread around the repeat interval.
  task automatic random_phase(input monitor_setting_t s, input int count);
    int          lo, hi, pos, dir, tmp, r;
    logic [63:0] r64, delta;
    lo = code_for_mv(int'(s.empty), s) - 30;
    hi = code_for_mv(int'(s.full), s) + 30;
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if (lo < 0) lo = 0;
    if (hi > (1 << ADC_BITS) - 1) hi = (1 << ADC_BITS) - 1;
    if (hi < lo) hi = lo;
    pos = lo + int'($urandom_range(0, hi - lo));
    dir = ($urandom_range(0, 1) == 0) ? -1 : 1;
    if ($urandom_range(0, 3) == 0) clock_us = '1 - TIME_BITS'($urandom_range(0, 5000));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) dir = -dir;
      pos = pos + dir * int'($urandom_range(0, 14));
      if (pos <= lo) begin
        pos = lo;
        dir = 1;
      end
      if (pos >= hi) begin
        pos = hi;
        dir = -1;
      end
      if ($urandom_range(0, 19) == 0) charging = ~charging;
      r   = int'($urandom_range(0, 99));
      r64 = {$urandom, $urandom};
      if (r < 55) delta = r64 % (64'(s.repeat_us) / 64'd4 + 64'd1);
      else if (r < 90) delta = 64'(s.repeat_us) + 64'(r64[3:0]) - 64'd8;
      else if (r < 97) delta = r64;
      else delta = 64'd0;
      clock_us = clock_us + delta[TIME_BITS-1:0];
      send_sample(($urandom_range(0, 99) < 8) ? ADC_BITS'($urandom) : ADC_BITS'(pos),
                  $urandom_range(0, 99) >= 10, charging, clock_us);
    end
  endtask

  // Result side: idle at random, and once on request hold off for a long stretch
  // so the block fills up and stops accepting samples.
  initial begin : result_sink
    int idle;
    out_ready_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      idle = idle_len(rx_streak);
      if (idle > 0) begin
        out_ready_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    monitor_setting_t s;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_ALERT_PCT;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    adc_raw_i        = '0;
    adc_ok_i         = 1'b0;
    charger_active_i = 1'b0;
    sample_time_us_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: walk the alert and protect logic through its cases.
    send_sample(12'd2160, 1'b1, 1'b0, 48'd1000);      // exactly on alert: first crossing
    send_sample(12'd2160, 1'b1, 1'b0, 48'd2000);      // inside repeat interval: quiet
    send_sample(12'd2160, 1'b1, 1'b0, 48'd60001000);  // interval elapsed: repeat alert
    send_sample(12'd2104, 1'b1, 1'b1, 48'd60001001);  // protect crossing while charging
    send_sample(12'd0, 1'b0, 1'b0, 48'd60001002);     // failed read keeps the percent
    send_sample(12'hFFF, 1'b1, 1'b0, 48'd60002000);   // full scale clamps, re-arms both
    send_sample(12'd0, 1'b1, 1'b0, 48'hFFFF_FFFF_FFF0); // below empty: stop recording
    send_sample(12'd0, 1'b1, 1'b0, 48'h0000_0000_0010); // timestamp wrapped, still recent
    send_sample(12'hAAA, 1'b1, 1'b1, 48'hAAAA_AAAA_AAAA);
    send_sample(12'h555, 1'b0, 1'b0, 48'h5555_5555_5555);
    settle();

    // Open lower resistor behaves like a failed read.
    s      = default_setting();
    s.rtop = 10'd1023;
    s.rbot = 10'd0;
    apply_setting(s);
    send_sample(12'hFFF, 1'b1, 1'b0, 48'd100);
    send_sample(12'd0, 1'b1, 1'b1, 48'd200);
    settle();

    // Full not above empty: all or nothing around empty.
    s       = default_setting();
    s.empty = 16'd3000;
    s.full  = 16'd1000;
    apply_setting(s);
    send_sample(12'hFFF, 1'b1, 1'b0, 48'd300);
    send_sample(12'd0, 1'b1, 1'b0, 48'd400);
    send_sample(12'd1862, 1'b1, 1'b0, 48'd500);       // lands exactly on empty
    settle();

    // Protect above alert: protect only counts once below alert too.
    s         = default_setting();
    s.alert   = 7'd10;
    s.protect = 7'd50;
    s.hyst    = 7'd0;
    apply_setting(s);
    send_sample(12'd2215, 1'b1, 1'b0, 48'd600);
    send_sample(12'd0, 1'b1, 1'b0, 48'd700);
    settle();

    // Register maxima.
    s.alert     = 7'd127;
    s.protect   = 7'd127;
    s.hyst      = 7'd127;
    s.empty     = 16'd0;
    s.full      = 16'hFFFF;
    s.rtop      = 10'd1023;
    s.rbot      = 10'd1023;
    s.repeat_us = '1;
    apply_setting(s);
    send_sample(12'hFFF, 1'b1, 1'b0, 48'd800);
    send_sample(12'hFFF, 1'b1, 1'b1, 48'd900);
    settle();

    // Register minima, zero repeat interval alerts on every sample at zero.
    s.alert     = 7'd0;
    s.protect   = 7'd0;
    s.hyst      = 7'd0;
    s.empty     = 16'd0;
    s.full      = 16'd1;
    s.rtop      = 10'd0;
    s.rbot      = 10'd1;
    s.repeat_us = '0;
    apply_setting(s);
    send_sample(12'd0, 1'b1, 1'b0, 48'd1000);
    send_sample(12'd0, 1'b1, 1'b1, 48'd1000);
    send_sample(12'd2, 1'b1, 1'b0, 48'd1001);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s = random_setting(p % 4 == 3);
      apply_setting(s);
      if (p == PRESSURE_PHASE) begin
        hold_off_req = 1'b1;
        tx_burst     = 1'b1;
      end
      random_phase(s, PHASE_SAMPLES);
      tx_burst = 1'b0;
      settle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("** battery_level_alert_monitor: PASSED **");
    end else begin
      $display("** battery_level_alert_monitor: FAILED **");
    end
    $finish;
  end

  // Watchdog: 60 ms is several times the slowest legitimate run.
  initial begin : watchdog
    #60_000_000;
    $display("** battery_level_alert_monitor: FAILED **");
    $finish;
  end

endmodule
